// ===== rtl/core/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants for the generational handle table
// Holds the transaction structs, function and status codes and table sizes.
// ----------------------------------------------------------------------------
package ght_pkg;

   localparam int MaxEntries = 32;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = $clog2(MaxEntries + 1);

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_CLOSE = 2'd2;
   localparam logic [1:0] FUNC_CLOSE_ALL = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_STALE = 3'd2;
   localparam logic [2:0] ST_TYPE = 3'd3;
   localparam logic [2:0] ST_RIGHTS = 3'd4;
   localparam logic [2:0] ST_NOSPACE = 3'd5;

   localparam logic CSR_RIGHTS_MASK = 1'b0;
   localparam logic CSR_HIGHEST_TYPE = 1'b1;

   typedef struct packed {
      logic [1:0] func;
      logic [63:0] handle;
      logic [3:0] entry_type;
      logic [63:0] rights;
      logic [63:0] object_ref;
      logic [7:0] close_tag;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [63:0] ret_handle;
      logic [63:0] ret_object;
      logic [3:0] type_out;
      logic [63:0] rights_out;
      logic [7:0] tag_out;
      logic close_event;
      logic [5:0] closed_total;
      logic [5:0] live_entries;
      logic last;
   } rsp_type;

   // one slot record as kept in the table memory
   typedef struct packed {
      logic [31:0] gen;
      logic [3:0] etype;
      logic [63:0] rights;
      logic [63:0] obj;
      logic [7:0] tag;
   } slot_type;

endpackage

// ===== rtl/core/generational_handle_table.sv =====
// Allocate, lookup and close pass through S_READ, S_EXEC and S_RESP (memory read,
// check, response) before a valid response; no new request is taken while one is in
// flight or while its response waits to be taken.
// Close-all visits all 32 slots in turn, each in S_SCAN then S_SCAN_EXEC, then raises
// its final response; each close event waits while the previous one is stalled.
// Reset clears used bits and count, sets both CSRs to all ones; untouched slots read gen 1.
// ----------------------------------------------------------------------------
// generational_handle_table: slot map with per-slot generation counters
// A small sequencer reads one slot record at a time and checks or updates it.
// ----------------------------------------------------------------------------
module generational_handle_table (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ght_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ght_pkg::rsp_type rsp_data,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_SCAN_EXEC = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   logic [2:0] state_ff, state_in;
   ght_pkg::req_type req_ff;
   logic [63:0] mask_ff;
   logic [3:0] hitype_ff;
   logic [ght_pkg::MaxEntries-1:0] used_ff, used_in;
   logic [ght_pkg::MaxEntries-1:0] touched_ff;
   logic [ght_pkg::CntW-1:0] count_ff, count_in;
   logic [ght_pkg::CntW-1:0] closed_ff, closed_in;
   logic [ght_pkg::IdxW-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   ght_pkg::rsp_type rsp_ff, rsp_in;

   ght_pkg::slot_type mem [ght_pkg::MaxEntries];
   ght_pkg::slot_type rd_ff;
   logic rd_touched_ff;
   logic [ght_pkg::IdxW-1:0] rd_addr;
   logic wr_en;
   ght_pkg::slot_type wr_data;

   // decode of the latched handle
   logic [31:0] h_slot, h_gen;
   logic h_bad;
   logic [ght_pkg::IdxW-1:0] h_idx;
   logic rights_bad;
   logic free_found;
   logic [ght_pkg::IdxW-1:0] free_idx;
   ght_pkg::slot_type cur;
   logic [31:0] next_gen;

   assign h_slot = req_ff.handle[31:0];
   assign h_gen = req_ff.handle[63:32];
   assign h_bad = (h_slot == 32'd0) || (h_slot > 32'(ght_pkg::MaxEntries)) ||
                  (h_gen == 32'd0);
   assign h_idx = ght_pkg::IdxW'(h_slot - 32'd1);
   assign rights_bad = (req_ff.rights & ~mask_ff) != 64'd0;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = ght_pkg::MaxEntries - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx = ght_pkg::IdxW'(i);
         end
      end
   end

   // untouched slots read as generation 1, all else zero
   always_comb begin
      cur = rd_ff;
      if (!rd_touched_ff) begin
         cur = '0;
         cur.gen = 32'd1;
      end
   end
   assign next_gen = (cur.gen == 32'hFFFF_FFFF) ? 32'd1 : cur.gen + 32'd1;

   always_comb begin
      case (state_ff)
         S_IDLE: rd_addr = (req_data.func == ght_pkg::FUNC_ALLOC) ? free_idx
                           : ght_pkg::IdxW'(req_data.handle[31:0] - 32'd1);
         default: rd_addr = idx_ff;
      endcase
   end

   // table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
      rd_touched_ff <= touched_ff[rd_addr];
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      wr_en = 1'b0;
      wr_data = cur;
      case (state_ff)
         S_IDLE: if (req_valid && !req_stall) begin
            state_in = (req_data.func == ght_pkg::FUNC_CLOSE_ALL) ? S_SCAN : S_READ;
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            state_in = S_RESP;
            if (req_ff.func == ght_pkg::FUNC_ALLOC) begin
               wr_data.gen = (cur.gen == 32'd0) ? 32'd1 : cur.gen;
               wr_data.etype = req_ff.entry_type;
               wr_data.rights = req_ff.rights;
               wr_data.obj = req_ff.object_ref;
               wr_data.tag = req_ff.close_tag;
               wr_en = !(req_ff.entry_type == 4'd0 || req_ff.entry_type > hitype_ff ||
                         req_ff.object_ref == 64'd0 || rights_bad ||
                         count_ff >= ght_pkg::CntW'(ght_pkg::MaxEntries) || !free_found);
            end else if (req_ff.func == ght_pkg::FUNC_CLOSE) begin
               wr_data = '0;
               wr_data.gen = next_gen;
               wr_en = !h_bad && used_ff[h_idx] && cur.gen == h_gen;
            end
         end
         S_SCAN: state_in = S_SCAN_EXEC;
         S_SCAN_EXEC: if (!rsp_stall || !rsp_valid_ff) begin
            wr_data = '0;
            wr_data.gen = next_gen;
            wr_en = used_ff[idx_ff];
            state_in = (idx_ff == ght_pkg::IdxW'(ght_pkg::MaxEntries - 1)) ? S_RESP : S_SCAN;
         end
         S_RESP: if (!rsp_stall || !rsp_valid_ff) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // response, slot bookkeeping and scan index
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      used_in = used_ff;
      count_in = count_ff;
      closed_in = closed_ff;
      idx_in = idx_ff;
      // drop the response once it is taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid && !req_stall) begin
            closed_in = '0;
            idx_in = (req_data.func == ght_pkg::FUNC_ALLOC) ? free_idx
                     : (req_data.func == ght_pkg::FUNC_CLOSE_ALL) ? '0
                     : ght_pkg::IdxW'(req_data.handle[31:0] - 32'd1);
         end
         S_EXEC: begin
            rsp_in = '0;
            rsp_in.last = 1'b1;
            rsp_in.live_entries = 6'(count_ff);
            case (req_ff.func)
               ght_pkg::FUNC_ALLOC: begin
                  if (req_ff.entry_type == 4'd0 || req_ff.entry_type > hitype_ff ||
                      req_ff.object_ref == 64'd0 || rights_bad) begin
                     rsp_in.status = ght_pkg::ST_INVALID;
                  end else if (!wr_en) begin
                     rsp_in.status = ght_pkg::ST_NOSPACE;
                  end else begin
                     rsp_in.ret_handle = {wr_data.gen, 32'(idx_ff) + 32'd1};
                     rsp_in.live_entries = 6'(count_ff + 1'b1);
                     used_in[idx_ff] = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               ght_pkg::FUNC_LOOKUP: begin
                  if (rights_bad || h_bad) rsp_in.status = ght_pkg::ST_INVALID;
                  else if (!used_ff[h_idx] || cur.gen != h_gen)
                     rsp_in.status = ght_pkg::ST_STALE;
                  else if (req_ff.entry_type != 4'd0 && cur.etype != req_ff.entry_type)
                     rsp_in.status = ght_pkg::ST_TYPE;
                  else if ((cur.rights & req_ff.rights) != req_ff.rights)
                     rsp_in.status = ght_pkg::ST_RIGHTS;
                  else begin
                     rsp_in.ret_object = cur.obj;
                     rsp_in.type_out = cur.etype;
                     rsp_in.rights_out = cur.rights;
                  end
               end
               default: begin
                  if (h_bad) rsp_in.status = ght_pkg::ST_INVALID;
                  else if (!wr_en) rsp_in.status = ght_pkg::ST_STALE;
                  else begin
                     rsp_in.ret_handle = req_ff.handle;
                     rsp_in.ret_object = cur.obj;
                     rsp_in.type_out = cur.etype;
                     rsp_in.tag_out = cur.tag;
                     rsp_in.close_event = 1'b1;
                     rsp_in.live_entries = 6'(count_ff - 1'b1);
                     used_in[idx_ff] = 1'b0;
                     count_in = count_ff - 1'b1;
                  end
               end
            endcase
         end
         // close-all: emit one event per live slot
         S_SCAN_EXEC: if (!rsp_stall || !rsp_valid_ff) begin
            idx_in = idx_ff + 1'b1;
            if (wr_en) begin
               rsp_in = '0;
               rsp_in.ret_handle = {cur.gen, 32'(idx_ff) + 32'd1};
               rsp_in.ret_object = cur.obj;
               rsp_in.type_out = cur.etype;
               rsp_in.tag_out = cur.tag;
               rsp_in.close_event = 1'b1;
               rsp_in.live_entries = 6'(count_ff - 1'b1);
               rsp_valid_in = 1'b1;
               used_in[idx_ff] = 1'b0;
               count_in = count_ff - 1'b1;
               closed_in = closed_ff + 1'b1;
            end
         end
         // final response
         S_RESP: if (!rsp_stall || !rsp_valid_ff) begin
            rsp_valid_in = 1'b1;
            if (req_ff.func == ght_pkg::FUNC_CLOSE_ALL) begin
               rsp_in = '0;
               rsp_in.closed_total = 6'(closed_ff);
               rsp_in.live_entries = 6'(count_ff);
               rsp_in.last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mask_ff <= '1;
         hitype_ff <= 4'hF;
         used_ff <= '0;
         touched_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         closed_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         count_ff <= count_in;
         closed_ff <= closed_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff <= rsp_in;
         if (csr_write) begin
            if (csr_index == ght_pkg::CSR_RIGHTS_MASK) mask_ff <= csr_wdata;
            else hitype_ff <= csr_wdata[3:0];
         end
         if (state_ff == S_IDLE && req_valid && !req_stall) req_ff <= req_data;
         if (wr_en) touched_ff[idx_ff] <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // checks
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == ght_pkg::CntW'($countones(used_ff))) else $error("count mismatch");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("accept while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");

endmodule
